[rtl/gzht_pkg.sv]
// ----------------------------------------------------------------------------
// gzht_pkg
// shared types, codes and helpers of the gzip header and trailer parser
// ----------------------------------------------------------------------------
package gzht_pkg;

    // default width of the byte position counters
    localparam int OFFSET_BITS_DEF = 32;

    // magic bytes, method and flag masks
    localparam logic [7:0] MAGIC_ID1      = 8'h1f;
    localparam logic [7:0] MAGIC_ID2      = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [4:0] FLG_MASK       = 5'h1f;
    localparam int         FLG_BIT_HCRC   = 1;
    localparam int         FLG_BIT_EXTRA  = 2;
    localparam int         FLG_BIT_NAME   = 3;
    localparam int         FLG_BIT_CMNT   = 4;

    // fixed header field length after the flag byte (mtime, xfl, os)
    localparam logic [15:0] FIXED_SKIP = 16'd6;
    // trailer length (crc32 and isize)
    localparam int TRAILER_BYTES = 8;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MAGIC  = 2'd1,
        ST_BAD_METHOD = 2'd2,
        ST_TRUNCATED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        PH_MAGIC0  = 4'd0,
        PH_MAGIC1  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_SKIP6   = 4'd4,
        PH_XLEN0   = 4'd5,
        PH_XLEN1   = 4'd6,
        PH_EXTRA   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_HCRC0   = 4'd10,
        PH_HCRC1   = 4'd11,
        PH_BODY    = 4'd12,
        PH_FAIL    = 4'd13
    } t_phase;

    // header summary handed from the parser to the top level
    typedef struct packed {
        t_phase      phase;
        t_status     status;
        logic [7:0]  method;
        logic [31:0] header_length;
        logic [31:0] compressed_length;
    } t_hdr_res;

    // clamp a length to 32 bits
    function automatic logic [31:0] f_sat32(input logic [63:0] v);
        logic [31:0] r;
        if (v > 64'h0000_0000_ffff_ffff) begin
            r = 32'hffff_ffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/gzht_in_if.sv]
// ----------------------------------------------------------------------------
// gzht_in_if
// byte stream channel into the parser, valid/ready handshake
// ----------------------------------------------------------------------------
interface gzht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/gzht_out_if.sv]
// ----------------------------------------------------------------------------
// gzht_out_if
// result channel out of the parser, valid/ready handshake
// ----------------------------------------------------------------------------
interface gzht_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  method;
    logic [31:0] header_length;
    logic [31:0] compressed_length;
    logic [31:0] crc_value;
    logic [31:0] uncompressed_length;

    modport source (
        output valid, output status, output method, output header_length,
        output compressed_length, output crc_value, output uncompressed_length,
        input ready
    );
    modport sink (
        input valid, input status, input method, input header_length,
        input compressed_length, input crc_value, input uncompressed_length,
        output ready
    );
endinterface

[rtl/gzht_core_top.sv]
// ----------------------------------------------------------------------------
// gzip_header_trailer_parser_core
// streaming gzip header walker with trailer extraction, one byte per item
// ----------------------------------------------------------------------------
// path: a final byte passes the input register and then loads the result register
// throughput: one byte per cycle, set by the single-step header walker
// a full result register stalls only a final byte; other bytes keep flowing
// reset: synchronous active-low i_rst_n clears the walker and both valid flags
// the walker also returns to its reset state after every final byte
module gzip_header_trailer_parser_core #(
    parameter int OFFSET_BITS = gzht_pkg::OFFSET_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gzht_in_if.sink   i_in,
    gzht_out_if.source o_out
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic              r_out_vld;
    gzht_pkg::t_status r_out_status;
    logic [7:0]        r_out_method;
    logic [31:0]       r_out_hlen;
    logic [31:0]       r_out_clen;
    logic [31:0]       r_out_crc;
    logic [31:0]       r_out_isize;

    logic               step;
    gzht_pkg::t_hdr_res hdr_res;
    logic [31:0]        win_crc;
    logic [31:0]        win_isize;
    logic               res_ok;

    // the buffered item moves on unless it is a final byte facing a full result slot
    assign step       = r_in_vld && (!r_in_last || !r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // header walker, positions and status
    gzht_hdr_fsm #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_hdr_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (hdr_res)
    );

    // trailer window
    gzht_tail_win u_tail_win (
        .i_clk   (i_clk),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_crc   (win_crc),
        .o_isize (win_isize)
    );

    // trailer fields only reported on a good file
    assign res_ok = (hdr_res.status == gzht_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_status <= hdr_res.status;
            r_out_method <= hdr_res.method;
            r_out_hlen   <= hdr_res.header_length;
            r_out_clen   <= hdr_res.compressed_length;
            r_out_crc    <= res_ok ? win_crc : 32'h0;
            r_out_isize  <= res_ok ? win_isize : 32'h0;
        end
    end

    assign o_out.valid               = r_out_vld;
    assign o_out.status              = r_out_status;
    assign o_out.method              = r_out_method;
    assign o_out.header_length       = r_out_hlen;
    assign o_out.compressed_length   = r_out_clen;
    assign o_out.crc_value           = r_out_crc;
    assign o_out.uncompressed_length = r_out_isize;

`ifndef NO_ASSERTIONS
    // a failed file reports no lengths and no trailer
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != gzht_pkg::ST_OK |->
            o_out.header_length == 32'h0 && o_out.compressed_length == 32'h0 &&
            o_out.crc_value == 32'h0 && o_out.uncompressed_length == 32'h0)
        else $error("nonzero fields on a failed result");

    // a final byte never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_last |-> !r_out_vld || o_out.ready)
        else $error("result overwritten while stalled");

    // the walker starts over at the magic bytes after each file
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in_last |=> hdr_res.phase == gzht_pkg::PH_MAGIC0)
        else $error("walker did not restart after final byte");

    // a raised result always comes from a final byte taken the cycle before
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(step && r_in_last))
        else $error("result raised without a final byte");
`endif

endmodule

[rtl/gzht_hdr_fsm.sv]
// ----------------------------------------------------------------------------
// gzht_hdr_fsm
// header walker: phase, flags, skip counter, positions and final status
// ----------------------------------------------------------------------------
module gzht_hdr_fsm #(
    parameter int OFFSET_BITS = gzht_pkg::OFFSET_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output gzht_pkg::t_hdr_res o_res
);

    gzht_pkg::t_phase  r_phase, n_phase;
    gzht_pkg::t_status r_err, n_err;
    logic [4:0]             r_flags, n_flags;
    logic [7:0]             r_method, n_method;
    logic [15:0]            r_skip, n_skip;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_hend, n_hend;
    logic [OFFSET_BITS-1:0] r_body, n_body;
    logic                   adv;
    gzht_pkg::t_phase       adv_from;
    logic                   body_ok;
    logic [OFFSET_BITS-1:0] clen;

    // first enabled header section at or after 'from'
    function automatic gzht_pkg::t_phase f_next_sect(input gzht_pkg::t_phase from,
                                                     input logic [4:0] flags);
        gzht_pkg::t_phase p;
        if (from <= gzht_pkg::PH_XLEN0 && flags[gzht_pkg::FLG_BIT_EXTRA]) begin
            p = gzht_pkg::PH_XLEN0;
        end else if (from <= gzht_pkg::PH_NAME && flags[gzht_pkg::FLG_BIT_NAME]) begin
            p = gzht_pkg::PH_NAME;
        end else if (from <= gzht_pkg::PH_COMMENT && flags[gzht_pkg::FLG_BIT_CMNT]) begin
            p = gzht_pkg::PH_COMMENT;
        end else if (from <= gzht_pkg::PH_HCRC0 && flags[gzht_pkg::FLG_BIT_HCRC]) begin
            p = gzht_pkg::PH_HCRC0;
        end else begin
            p = gzht_pkg::PH_BODY;
        end
        return p;
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_err    = r_err;
        n_flags  = r_flags;
        n_method = r_method;
        n_skip   = r_skip;
        n_hend   = r_hend;
        n_body   = r_body;
        n_pos    = (&r_pos) ? r_pos : r_pos + 1'b1;
        adv      = 1'b0;
        adv_from = gzht_pkg::PH_BODY;

        case (r_phase)
            gzht_pkg::PH_MAGIC0: begin
                if (i_byte != gzht_pkg::MAGIC_ID1) begin
                    n_err   = gzht_pkg::ST_BAD_MAGIC;
                    n_phase = gzht_pkg::PH_FAIL;
                end else begin
                    n_phase = gzht_pkg::PH_MAGIC1;
                end
            end
            gzht_pkg::PH_MAGIC1: begin
                if (i_byte != gzht_pkg::MAGIC_ID2) begin
                    n_err   = gzht_pkg::ST_BAD_MAGIC;
                    n_phase = gzht_pkg::PH_FAIL;
                end else begin
                    n_phase = gzht_pkg::PH_METHOD;
                end
            end
            gzht_pkg::PH_METHOD: begin
                n_method = i_byte;
                n_phase  = gzht_pkg::PH_FLAGS;
            end
            gzht_pkg::PH_FLAGS: begin
                n_flags = i_byte[4:0] & gzht_pkg::FLG_MASK;
                if (r_method != gzht_pkg::METHOD_DEFLATE) begin
                    n_err   = gzht_pkg::ST_BAD_METHOD;
                    n_phase = gzht_pkg::PH_FAIL;
                end else begin
                    n_skip  = gzht_pkg::FIXED_SKIP;
                    n_phase = gzht_pkg::PH_SKIP6;
                end
            end
            gzht_pkg::PH_SKIP6: begin
                n_skip   = r_skip - 1'b1;
                adv      = (n_skip == '0);
                adv_from = gzht_pkg::PH_XLEN0;
            end
            gzht_pkg::PH_XLEN0: begin
                n_skip  = {8'h00, i_byte};
                n_phase = gzht_pkg::PH_XLEN1;
            end
            gzht_pkg::PH_XLEN1: begin
                n_skip   = {i_byte, r_skip[7:0]};
                adv_from = gzht_pkg::PH_NAME;
                if (n_skip == '0) begin
                    adv = 1'b1;
                end else begin
                    n_phase = gzht_pkg::PH_EXTRA;
                end
            end
            gzht_pkg::PH_EXTRA: begin
                n_skip   = r_skip - 1'b1;
                adv      = (n_skip == '0);
                adv_from = gzht_pkg::PH_NAME;
            end
            gzht_pkg::PH_NAME: begin
                adv      = (i_byte == 8'h00);
                adv_from = gzht_pkg::PH_COMMENT;
            end
            gzht_pkg::PH_COMMENT: begin
                adv      = (i_byte == 8'h00);
                adv_from = gzht_pkg::PH_HCRC0;
            end
            gzht_pkg::PH_HCRC0: begin
                n_phase = gzht_pkg::PH_HCRC1;
            end
            gzht_pkg::PH_HCRC1: begin
                adv      = 1'b1;
                adv_from = gzht_pkg::PH_BODY;
            end
            gzht_pkg::PH_BODY: begin
                // distance from header end grows until the position saturates
                n_body = r_body + {{(OFFSET_BITS-1){1'b0}}, ~(&r_pos)};
            end
            default: begin
                n_phase = gzht_pkg::PH_FAIL;
            end
        endcase

        if (adv) begin
            n_phase = f_next_sect(adv_from, r_flags);
            if (n_phase == gzht_pkg::PH_BODY) begin
                n_hend = n_pos;
                n_body = '0;
            end
        end
    end

    // final status from the updated state
    assign body_ok = (n_body[OFFSET_BITS-1:3] != '0);
    assign clen    = n_body - OFFSET_BITS'(gzht_pkg::TRAILER_BYTES);

    always_comb begin
        o_res.phase             = r_phase;
        o_res.method            = n_method;
        o_res.header_length     = '0;
        o_res.compressed_length = '0;
        if (n_err != gzht_pkg::ST_OK) begin
            o_res.status = n_err;
        end else if (n_phase != gzht_pkg::PH_BODY || !body_ok) begin
            o_res.status = gzht_pkg::ST_TRUNCATED;
        end else begin
            o_res.status            = gzht_pkg::ST_OK;
            o_res.header_length     = gzht_pkg::f_sat32(64'(n_hend));
            o_res.compressed_length = gzht_pkg::f_sat32(64'(clen));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase  <= gzht_pkg::PH_MAGIC0;
            r_err    <= gzht_pkg::ST_OK;
            r_flags  <= '0;
            r_method <= '0;
            r_skip   <= '0;
            r_pos    <= '0;
            r_hend   <= '0;
            r_body   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_err    <= n_err;
            r_flags  <= n_flags;
            r_method <= n_method;
            r_skip   <= n_skip;
            r_pos    <= n_pos;
            r_hend   <= n_hend;
            r_body   <= n_body;
        end
    end

endmodule

[rtl/gzht_tail_win.sv]
// ----------------------------------------------------------------------------
// gzht_tail_win
// eight-byte window of the newest bytes, trailer fields reassembled
// ----------------------------------------------------------------------------
module gzht_tail_win (
    input  logic        i_clk,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc,
    output logic [31:0] o_isize
);

    logic [63:0] r_win;
    logic [63:0] n_win;

    // newest byte in the low bits
    assign n_win = {r_win[55:0], i_byte};

    // little-endian: oldest trailer byte is the least significant
    assign o_crc   = {n_win[39:32], n_win[47:40], n_win[55:48], n_win[63:56]};
    assign o_isize = {n_win[7:0], n_win[15:8], n_win[23:16], n_win[31:24]};

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win <= n_win;
        end
    end

endmodule
